// ----- design/apalarm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package apalarm_pkg;

    localparam int TimeW   = 32;
    localparam int KindW   = 2;
    localparam int CntW    = 5;            // divider step counter, one step per quotient bit
    localparam int CfgAddrW = 1;
    localparam int InDataW  = 104;         // 97 payload bits padded to whole bytes
    localparam int OutDataW = 40;          // 33 payload bits padded to whole bytes

    localparam logic [KindW-1:0] KIND_CHECK = 2'd0;
    localparam logic [KindW-1:0] KIND_REARM = 2'd1;
    localparam logic [KindW-1:0] KIND_LOAD  = 2'd2;

    localparam logic [CfgAddrW-1:0] REG_PERIOD = 1'd0;
    localparam logic [CfgAddrW-1:0] REG_SPREAD = 1'd1;

    localparam logic [CntW-1:0] DIV_LAST = CntW'(TimeW - 1);

    // controller -> datapath
    typedef struct packed {
        logic load_item;    // latch input word, evaluate due / rearm need
        logic t_clear;      // zero period: rearm clears due time
        logic div_start_a;  // now % period
        logic div_start_b;  // random % clamped spread
        logic div_step;     // one restoring step
        logic t_align;      // t = now + period - rem, compute clamped spread
        logic t_jitter;     // t += rem
        logic commit;       // update due time, present result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_rearm;
        logic period_zero;
        logic plus_zero;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- design/aligned_periodic_alarm_with_jitter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Periodic alarm with random jitter. One word in gives one word out. A check
// word reports due when a due time is set and now has reached it, and may
// rearm; a rearm word aligns the due time to the next period multiple strictly
// after now, then adds random % min(spread, period/2); a load word sets the due
// time (zero load means rearm). Zero period makes a rearm clear the due time.
// Sums wrap at 2^32. A word that needs no rearm goes straight to the commit; a
// rearm runs a remainder pass for the alignment, and one more for the jitter
// when the clamped spread is not zero. Both passes use one shared restoring
// divider (one bit per cycle); a result still waiting in the output register
// holds back the commit of the next one.
// One word is in flight at a time; s_tready returns as soon as the result is
// in the output register, which holds it until taken. Register writes only
// change the register; issue a rearm after changing one.

module aligned_periodic_alarm_with_jitter_top
    import apalarm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] now_secs, [63:32] random_word, [64] rearm_when_due,
    // [96:65] load_value, [103:97] zero
    input  wire logic [InDataW-1:0]   s_tdata,
    // [1:0] kind
    input  wire logic [KindW-1:0]     s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] due, [32:1] due_time, [39:33] zero
    output logic [OutDataW-1:0]       m_tdata,
    // configuration: 0 period_secs, 1 spread_secs
    input  wire logic                 cfg_we,
    input  wire logic [CfgAddrW-1:0]  cfg_addr,
    input  wire logic [TimeW-1:0]     cfg_wdata
);

    cmd_t             cmd;
    status_t          st;
    logic             out_due;
    logic [TimeW-1:0] out_due_time;

    apalarm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    apalarm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_kind      (s_tuser),
        .in_now       (s_tdata[31:0]),
        .in_rnd       (s_tdata[63:32]),
        .in_rflag     (s_tdata[64]),
        .in_load      (s_tdata[96:65]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_due      (out_due),
        .out_due_time (out_due_time)
    );

    assign m_tdata = {{(OutDataW - TimeW - 1){1'b0}}, out_due_time, out_due};

    // one word at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous word still in work");

    // a new result only appears from a controller commit
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // divider start is followed by stepping
    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start_a || cmd.div_start_b) |=> cmd.div_step)
        else $error("divider started but not stepping");

endmodule

`default_nettype wire

// ----- design/apalarm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apalarm_dp
    import apalarm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output status_t                   st,
    input  wire logic                 cfg_we,
    input  wire logic [CfgAddrW-1:0]  cfg_addr,
    input  wire logic [TimeW-1:0]     cfg_wdata,
    input  wire logic [KindW-1:0]     in_kind,
    input  wire logic [TimeW-1:0]     in_now,
    input  wire logic [TimeW-1:0]     in_rnd,
    input  wire logic                 in_rflag,
    input  wire logic [TimeW-1:0]     in_load,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_due,
    output logic [TimeW-1:0]          out_due_time
);

    logic [TimeW-1:0] period_reg, spread_reg;
    logic [TimeW-1:0] next_due_reg, next_due_next;
    logic [TimeW-1:0] now_reg, rnd_reg, load_reg;
    logic             due_reg, need_rearm_reg, load_direct_reg;
    logic [TimeW-1:0] t_reg, plus_reg;
    logic [TimeW-1:0] rem_reg, dvd_reg, dsr_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             valid_reg, due_out_reg;
    logic [TimeW-1:0] due_time_out_reg;

    logic             due_now;
    logic [TimeW:0]   rem_shift;
    logic [TimeW:0]   rem_diff;
    logic [TimeW-1:0] half_period;

    assign due_now     = (in_kind == KIND_CHECK) && (next_due_reg != '0)
                         && (in_now >= next_due_reg);
    assign rem_shift   = {rem_reg, dvd_reg[TimeW-1]};
    assign rem_diff    = rem_shift - {1'b0, dsr_reg};
    assign half_period = period_reg >> 1;

    always_comb begin
        next_due_next = next_due_reg;
        if (load_direct_reg) begin
            next_due_next = load_reg;
        end else if (need_rearm_reg) begin
            next_due_next = t_reg;
        end
    end

    // configuration and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= '0;
            spread_reg   <= '0;
            next_due_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_PERIOD: period_reg <= cfg_wdata;
                    REG_SPREAD: spread_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                next_due_reg <= next_due_next;
                valid_reg    <= 1'b1;
            end else if (out_ready) begin
                valid_reg    <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            now_reg         <= in_now;
            rnd_reg         <= in_rnd;
            load_reg        <= in_load;
            due_reg         <= due_now;
            load_direct_reg <= (in_kind == KIND_LOAD) && (in_load != '0);
            need_rearm_reg  <= (in_kind == KIND_REARM)
                               || ((in_kind == KIND_LOAD) && (in_load == '0))
                               || (due_now && in_rflag);
        end
        if (cmd.t_clear) begin
            t_reg <= '0;
        end else if (cmd.t_align) begin
            t_reg <= now_reg + (period_reg - rem_reg);
        end else if (cmd.t_jitter) begin
            t_reg <= t_reg + rem_reg;
        end
        if (cmd.t_align) begin
            plus_reg <= (spread_reg > half_period) ? half_period : spread_reg;
        end
        if (cmd.commit) begin
            due_out_reg      <= due_reg;
            due_time_out_reg <= next_due_next;
        end
    end

    // shared restoring divider, remainder only
    always_ff @(posedge aclk) begin
        if (cmd.div_start_a || cmd.div_start_b) begin
            rem_reg <= '0;
            cnt_reg <= '0;
            dvd_reg <= cmd.div_start_a ? now_reg : rnd_reg;
            dsr_reg <= cmd.div_start_a ? period_reg : plus_reg;
        end else if (cmd.div_step) begin
            rem_reg <= rem_diff[TimeW] ? rem_shift[TimeW-1:0] : rem_diff[TimeW-1:0];
            dvd_reg <= {dvd_reg[TimeW-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign st.need_rearm  = need_rearm_reg;
    assign st.period_zero = (period_reg == '0);
    assign st.plus_zero   = (plus_reg == '0);
    assign st.div_last    = (cnt_reg == DIV_LAST);
    assign st.out_free    = !valid_reg || out_ready;

    assign out_valid    = valid_reg;
    assign out_due      = due_out_reg;
    assign out_due_time = due_time_out_reg;

endmodule

`default_nettype wire

// ----- design/apalarm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apalarm_ctrl
    import apalarm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV1   = 3'd2;
    localparam logic [2:0] S_ALIGN  = 3'd3;
    localparam logic [2:0] S_JCHK   = 3'd4;
    localparam logic [2:0] S_DIV2   = 3'd5;
    localparam logic [2:0] S_JADD   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (!st.need_rearm) begin
                    state_next = S_FINISH;
                end else if (st.period_zero) begin
                    cmd.t_clear = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.div_start_a = 1'b1;
                    state_next      = S_DIV1;
                end
            end
            S_DIV1: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN: begin
                cmd.t_align = 1'b1;
                state_next  = S_JCHK;
            end
            S_JCHK: begin
                if (st.plus_zero) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.div_start_b = 1'b1;
                    state_next      = S_DIV2;
                end
            end
            S_DIV2: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = S_JADD;
                end
            end
            S_JADD: begin
                cmd.t_jitter = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/aligned_periodic_alarm_with_jitter_top_tb.sv -----
`timescale 1ns / 1ps

module aligned_periodic_alarm_with_jitter_top_tb;
    import apalarm_pkg::*;

    // kind code the block must ignore
    localparam logic [KindW-1:0] KIND_RESERVED = 2'd3;
    // cycles with no word moved on either side before the run is declared hung
    localparam int IDLE_LIMIT = 5000;
    // length of the long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 400;
    // worst-case block latency plus margin
    localparam int SETTLE_CYCLES = 90;

    typedef struct packed {
        logic             due;
        logic [TimeW-1:0] due_time;
    } alarm_result_t;

    // Tracks the alarm state and the results the block owes.
    class alarm_checker;
        logic [TimeW-1:0] period;
        logic [TimeW-1:0] spread;
        logic [TimeW-1:0] next_due;
        alarm_result_t    owed[$];
        int               errors;
        int               n_words;
        int               n_due;
        int               n_rearm;
        int               n_cleared;
        int               n_reserved;

        function new();
            period   = '0;
            spread   = '0;
            next_due = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CfgAddrW-1:0] addr, logic [TimeW-1:0] val);
            if (addr == REG_PERIOD) begin
                period = val;
            end else if (addr == REG_SPREAD) begin
                spread = val;
            end
        endfunction

        // next period boundary strictly after now, plus jitter; wraps at 2^32
        function logic [TimeW-1:0] aligned_due(logic [TimeW-1:0] now, logic [TimeW-1:0] rnd);
            logic [TimeW-1:0] t;
            logic [TimeW-1:0] lim;
            logic [TimeW-1:0] plus;
            n_rearm++;
            if (period == '0) begin
                n_cleared++;
                return '0;
            end
            t = now + (period - (now % period));
            if (spread != '0) begin
                lim  = period >> 1;
                plus = (spread > lim) ? lim : spread;
                if (plus != '0) begin
                    t = t + (rnd % plus);
                end
            end
            if (t == '0) begin
                n_cleared++;
            end
            return t;
        endfunction

        function void note_word(logic [KindW-1:0] kind, logic [TimeW-1:0] now,
                                logic [TimeW-1:0] rnd, logic rearm, logic [TimeW-1:0] load);
            alarm_result_t r;
            r.due = 1'b0;
            n_words++;
            case (kind)
                KIND_CHECK: begin
                    if (next_due != '0 && now >= next_due) begin
                        r.due = 1'b1;
                        n_due++;
                        if (rearm) begin
                            next_due = aligned_due(now, rnd);
                        end
                    end
                end
                KIND_REARM: begin
                    next_due = aligned_due(now, rnd);
                end
                KIND_LOAD: begin
                    next_due = (load != '0) ? load : aligned_due(now, rnd);
                end
                default: begin
                    n_reserved++;
                end
            endcase
            r.due_time = next_due;
            owed.push_back(r);
        endfunction

        function void check_word(logic due, logic [TimeW-1:0] due_time);
            alarm_result_t exp_r;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: unexpected result due=%0b due_time=%h", $realtime, due,
                             due_time);
                end
                return;
            end
            exp_r = owed.pop_front();
            if (due !== exp_r.due || due_time !== exp_r.due_time) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch due exp %0b got %0b, due_time exp %h got %h",
                             $realtime, exp_r.due, due, exp_r.due_time, due_time);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic [KindW-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [TimeW-1:0]    cfg_wdata;

    alarm_checker sb = new();

    // pacing knobs for the sender and the receiver, plus setting and watchdog counters
    bit tx_burst;
    bit rx_burst;
    bit hold_req;
    int n_settings;
    int idle_cycles;

    aligned_periodic_alarm_with_jitter_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Both handshakes are sampled here at the rising edge, before the block's
    // registers move. Result check first; the word accepted at the same edge
    // belongs to a later result anyway.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata[0], m_tdata[32:1]);
            end
            if (s_tvalid && s_tready) begin
                sb.note_word(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[64],
                             s_tdata[96:65]);
            end
        end
    end

    // Watchdog: counts edges where neither side moves a word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stall per result, zero in burst mode, and one long
    // hold-off on request so the block backs up into its input.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge aclk) m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Register write, only while nothing is in flight.
    task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [TimeW-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk) cfg_we <= 1'b0;
        sb.set_reg(addr, val);
    endtask

    // Sender drops tvalid and pauses until every owed result is back, then
    // lets the block settle.
    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_alarm(logic [TimeW-1:0] period, logic [TimeW-1:0] spread);
        drain();
        write_reg(REG_PERIOD, period);
        write_reg(REG_SPREAD, spread);
        n_settings++;
    endtask

    // One input word with a random lead-in gap; tvalid stays up across
    // back-to-back words.
    task automatic send_word(logic [KindW-1:0] kind, logic [TimeW-1:0] now,
                             logic [TimeW-1:0] rnd, logic rearm, logic [TimeW-1:0] load);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, load, rearm, rnd, now};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // Random words steered around the current due time so checks do fire.
    task automatic run_setting(logic [TimeW-1:0] period, logic [TimeW-1:0] spread,
                               int n, bit hold);
        logic [TimeW-1:0] wall;
        logic [TimeW-1:0] now;
        logic [TimeW-1:0] load;
        logic [TimeW-1:0] step_max;
        logic [KindW-1:0] kind;
        int               pick;
        set_alarm(period, spread);
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        hold_req = hold;
        wall = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                           : $urandom;
        step_max = period >> 2;
        if (step_max > 5000) begin
            step_max = 5000;
        end
        if (step_max == '0) begin
            step_max = 2;
        end
        // a fresh rearm starts each setting, as software would
        send_word(KIND_REARM, wall, $urandom, 1'b0, '0);
        for (int i = 0; i < n; i++) begin
            wall = wall + $urandom_range(0, step_max);
            if (sb.next_due != '0 && $urandom_range(0, 3) == 0) begin
                wall = sb.next_due - 1 + $urandom_range(0, 2);
            end
            now  = ($urandom_range(0, 19) == 0) ? $urandom : wall;
            load = $urandom_range(0, 1) ? $urandom : '0;
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                kind = KIND_CHECK;
            end else if (pick < 78) begin
                kind = KIND_REARM;
            end else if (pick < 95) begin
                kind = KIND_LOAD;
                case ($urandom_range(0, 3))
                    0: load = '0;
                    1: load = $urandom;
                    default: load = wall + $urandom_range(1, 4 * step_max + 1);
                endcase
            end else begin
                kind = KIND_RESERVED;
            end
            send_word(kind, now, $urandom, $urandom_range(0, 3) != 0, load);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_CHECK;
        cfg_we    = 1'b0;
        cfg_addr  = REG_PERIOD;
        cfg_wdata = '0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;
        hold_req  = 1'b0;
        n_settings  = 1;
        idle_cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed part, reset registers: alarm disabled.
        send_word(KIND_CHECK, 32'd0, 32'd0, 1'b1, '0);            // nothing set, not due
        send_word(KIND_REARM, 32'd1234, $urandom, 1'b0, '0);      // zero period clears
        send_word(KIND_LOAD, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);  // explicit max due time
        send_word(KIND_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0); // due, rearm clears
        send_word(KIND_LOAD, 32'd50, $urandom, 1'b0, 32'd0);      // zero load acts as rearm
        send_word(KIND_LOAD, 32'd0, 32'd0, 1'b0, 32'd5);
        send_word(KIND_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_word(KIND_CHECK, 32'd4, 32'd0, 1'b1, '0);            // one short of due
        send_word(KIND_CHECK, 32'd5, 32'd0, 1'b0, '0);            // exactly due, keep

        // Period 16, no jitter: alignment and wrap of the aligned sum.
        set_alarm(32'd16, 32'd0);
        send_word(KIND_REARM, 32'd0, $urandom, 1'b0, '0);
        send_word(KIND_REARM, 32'd15, $urandom, 1'b0, '0);
        send_word(KIND_REARM, 32'd16, $urandom, 1'b0, '0);        // strictly after now
        send_word(KIND_REARM, 32'hFFFF_FFF5, $urandom, 1'b0, '0); // wraps to zero
        send_word(KIND_LOAD, 32'd100, $urandom, 1'b0, 32'd0);
        send_word(KIND_CHECK, 32'd112, $urandom, 1'b1, '0);       // due and rearms

        // Period 1: half period is zero, so the spread is clamped away.
        set_alarm(32'd1, 32'd5);
        send_word(KIND_REARM, 32'd7, 32'hFFFF_FFFF, 1'b0, '0);

        // Spread larger than half the period gets clamped.
        set_alarm(32'd100, 32'd1000);
        send_word(KIND_REARM, 32'd250, 32'hFFFF_FFFF, 1'b0, '0);
        send_word(KIND_CHECK, 32'd400, 32'd0, 1'b1, '0);

        // All-ones registers: aligned sum wraps, and the jitter add can wrap too.
        set_alarm(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_REARM, 32'd0, 32'hFFFF_FFFE, 1'b0, '0);
        send_word(KIND_REARM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        send_word(KIND_CHECK, 32'hFFFF_FFFF, $urandom, 1'b1, '0);

        // Random part over a spread of settings, extremes included.
        run_setting(32'd60, 32'd10, 110, 1'b0);
        run_setting(32'd1, 32'd0, 110, 1'b1);
        run_setting(32'd2, 32'd1, 110, 1'b0);
        run_setting(32'd3600, 32'd300, 110, 1'b0);
        run_setting(32'd7, 32'd100, 110, 1'b0);
        run_setting(32'd0, 32'hFFFF_FFFF, 100, 1'b1);
        run_setting(32'd1000, 32'd0, 110, 1'b0);
        run_setting(32'hFFFF_FFFF, 32'd0, 100, 1'b0);
        run_setting(32'h8000_0000, 32'hFFFF_FFFF, 100, 1'b0);
        run_setting($urandom_range(3, 20000), $urandom_range(0, 20000), 110, 1'b0);

        @(negedge aclk) s_tvalid <= 1'b0;
        drain();

        $display("covered %0d words under %0d register settings, %0d reserved kinds",
                 sb.n_words, n_settings, sb.n_reserved);
        $display("due reports %0d, rearms %0d (%0d left no due time), mismatches %0d",
                 sb.n_due, sb.n_rearm, sb.n_cleared, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/apalarm_pkg.sv
design/apalarm_dp.sv
design/apalarm_ctrl.sv
design/aligned_periodic_alarm_with_jitter_top.sv
tb/aligned_periodic_alarm_with_jitter_top_tb.sv
